// File: sv/sfp_pkg.sv
package sfp_pkg;

  // Frame constants
  localparam logic [7:0]  SYNC0_BYTE     = 8'h55;
  localparam logic [7:0]  SYNC1_BYTE     = 8'hAA;
  localparam logic [7:0]  CR_BYTE        = 8'h0D;
  localparam logic [7:0]  LF_BYTE        = 8'h0A;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [15:0] FRAME_OVERHEAD = 16'd19;
  localparam int          MAX_WORDS      = 2048;
  localparam int          QUEUE_DEPTH    = 2;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEV_TYPE  = 2'd0;
  localparam logic [1:0] CFG_SAMPLE_RATE = 2'd1;
  localparam logic [1:0] CFG_WORDS_PER_FRAME = 2'd2;

  typedef struct packed {
    logic [7:0]  dev_type;
    logic [31:0] sample_rate;
    logic [11:0] words_per_frame;
  } cfg_t;

  typedef struct packed {
    logic [31:0] data_word;
    logic [31:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_first;
    logic       frame_last;
  } out_item_t;

  // One classified request waiting for the byte sequencer
  typedef struct packed {
    logic [31:0] data_word;
    logic [31:0] timestamp;
    logic        first;
    logic        last;
  } qent_t;

  // Byte positions within a frame
  typedef enum logic [4:0] {
    BP_SYNC0, BP_SYNC1, BP_LEN_LO, BP_LEN_HI, BP_DEV,
    BP_RATE0, BP_RATE1, BP_RATE2, BP_RATE3,
    BP_TS0, BP_TS1, BP_TS2, BP_TS3,
    BP_CNT_LO, BP_CNT_HI,
    BP_DATA0, BP_DATA1, BP_DATA2, BP_DATA3,
    BP_CRC_LO, BP_CRC_HI, BP_CR, BP_LF
  } byte_pos_t;

  // CRC-16/CCITT-FALSE update over one byte, MSB first
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Byte of the frame at a given position
  function automatic logic [7:0] frame_byte(byte_pos_t pos, qent_t e, cfg_t cfg,
                                             logic [15:0] crc);
    logic [15:0] len;
    logic [7:0]  b;
    len = FRAME_OVERHEAD + {2'b00, cfg.words_per_frame, 2'b00};
    case (pos)
      BP_SYNC0:  b = SYNC0_BYTE;
      BP_SYNC1:  b = SYNC1_BYTE;
      BP_LEN_LO: b = len[7:0];
      BP_LEN_HI: b = len[15:8];
      BP_DEV:    b = cfg.dev_type;
      BP_RATE0:  b = cfg.sample_rate[7:0];
      BP_RATE1:  b = cfg.sample_rate[15:8];
      BP_RATE2:  b = cfg.sample_rate[23:16];
      BP_RATE3:  b = cfg.sample_rate[31:24];
      BP_TS0:    b = e.timestamp[7:0];
      BP_TS1:    b = e.timestamp[15:8];
      BP_TS2:    b = e.timestamp[23:16];
      BP_TS3:    b = e.timestamp[31:24];
      BP_CNT_LO: b = cfg.words_per_frame[7:0];
      BP_CNT_HI: b = {4'h0, cfg.words_per_frame[11:8]};
      BP_DATA0:  b = e.data_word[7:0];
      BP_DATA1:  b = e.data_word[15:8];
      BP_DATA2:  b = e.data_word[23:16];
      BP_DATA3:  b = e.data_word[31:24];
      BP_CRC_LO: b = crc[7:0];
      BP_CRC_HI: b = crc[15:8];
      BP_CR:     b = CR_BYTE;
      BP_LF:     b = LF_BYTE;
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: sv/sfp_stream_if.sv
interface sfp_stream_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/sfp_queue.sv
module sfp_queue
  import sfp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_ent,
  input  logic  pop,
  output qent_t head,
  output logic  not_empty,
  output logic  full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qent_t              mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

// File: sv/sfp_front.sv
module sfp_front
  import sfp_pkg::*;
#(
  parameter int MAX_FRAME_WORDS = MAX_WORDS
)
(
  input  logic   clk,
  input  logic   rst_n,
  sfp_stream_if.sink in_ch,
  input  cfg_t   cfg,
  input  logic   cfg_clear,
  input  logic   q_full,
  output logic   push,
  output qent_t  push_ent
);

  logic [11:0] word_index_r, word_index_nxt;
  logic        accept;
  logic        enabled;
  logic        first;
  logic        last;
  logic [12:0] index_inc;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Classify: drop when framing is disabled, mark frame start and end
  assign enabled = (cfg.words_per_frame != 12'd0)
                && ({3'b000, cfg.words_per_frame} <= 15'(MAX_FRAME_WORDS))
                && (cfg.sample_rate != 32'd0);
  assign index_inc = {1'b0, word_index_r} + 13'd1;
  assign first     = (word_index_r == 12'd0);
  assign last      = (index_inc >= {1'b0, cfg.words_per_frame});
  assign push      = accept && enabled;

  always_comb begin
    push_ent.data_word = in_ch.data.data_word;
    push_ent.timestamp = in_ch.data.timestamp;
    push_ent.first     = first;
    push_ent.last      = last;
  end

  // Track words in the open frame; a write to a known register abandons the frame
  always_comb begin
    word_index_nxt = word_index_r;
    if (cfg_clear) begin
      word_index_nxt = 12'd0;
    end else if (push) begin
      word_index_nxt = last ? 12'd0 : index_inc[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_index_r <= 12'd0;
    end else begin
      word_index_r <= word_index_nxt;
    end
  end

endmodule

// File: sv/sfp_back.sv
module sfp_back
  import sfp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  qent_t  head,
  input  logic   q_not_empty,
  output logic   pop,
  sfp_stream_if.source out_ch
);

  byte_pos_t   pos_r, pos_nxt;
  logic        started_r, started_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_vld_r, out_vld_nxt;
  out_item_t   out_item_r, out_item_nxt;

  byte_pos_t   cur_pos;
  byte_pos_t   end_pos;
  logic        load;
  logic        emit;
  logic [7:0]  cur_byte;
  logic [15:0] crc_base;

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_item_r;

  // Output register takes a new byte when empty or being drained
  assign load = !out_vld_r || out_ch.ready;
  assign emit = load && q_not_empty;

  assign cur_pos  = started_r ? pos_r : (head.first ? BP_SYNC0 : BP_DATA0);
  assign end_pos  = head.last ? BP_LF : BP_DATA3;
  assign crc_base = (cur_pos == BP_SYNC0) ? CRC_INIT : crc_r;
  assign cur_byte = frame_byte(cur_pos, head, cfg, crc_r);
  assign pop      = emit && (cur_pos == end_pos);

  // Step through the request's bytes, folding header and payload into the CRC
  always_comb begin
    pos_nxt      = pos_r;
    started_nxt  = started_r;
    crc_nxt      = crc_r;
    out_vld_nxt  = out_vld_r;
    out_item_nxt = out_item_r;
    if (load) begin
      out_vld_nxt = q_not_empty;
    end
    if (emit) begin
      out_item_nxt.out_byte    = cur_byte;
      out_item_nxt.frame_first = (cur_pos == BP_SYNC0);
      out_item_nxt.frame_last  = (cur_pos == BP_LF);
      if (cur_pos < BP_CRC_LO) begin
        crc_nxt = crc16_byte(crc_base, cur_byte);
      end
      if (cur_pos == end_pos) begin
        started_nxt = 1'b0;
      end else begin
        started_nxt = 1'b1;
        pos_nxt     = byte_pos_t'(cur_pos + 5'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= BP_SYNC0;
      started_r <= 1'b0;
      crc_r     <= CRC_INIT;
      out_vld_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      started_r <= started_nxt;
      crc_r     <= crc_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule

// File: sv/sample_frame_packer_crc16_unit.sv
// Sample frame packer: takes 32-bit sample words and streams framed bytes,
// one byte per cycle on the result channel while that channel is ready. A
// word that opens a frame yields the 15-byte header (55 AA, length 19+4N,
// device type, sample rate, timestamp, count N) and its four payload bytes;
// every other word yields four bytes; the word that closes a frame adds
// CRC-16/CCITT-FALSE (low byte first) and 0D 0A. A single output byte
// register holds each byte for the result channel. A two-entry queue
// decouples input acceptance from the byte sequencer, so input is taken
// while earlier words are still being sent. Words are dropped with no output
// when the word count is zero or above MAX_FRAME_WORDS (2048 by default) or
// the sample rate is zero. Any write to a known register index abandons the
// open frame.
module sample_frame_packer_crc16_unit
  import sfp_pkg::*;
#(
  parameter int MAX_FRAME_WORDS = MAX_WORDS
)
(
  input  logic        clk,
  input  logic        rst_n,
  sfp_stream_if.sink   in_ch,
  sfp_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cfg_t  cfg_r, cfg_nxt;
  logic  cfg_clear;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_not_empty;
  qent_t push_ent;
  qent_t head;

  // Register writes; unknown indexes are ignored
  always_comb begin
    cfg_nxt   = cfg_r;
    cfg_clear = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DEV_TYPE: begin
          cfg_nxt.dev_type = cfg_wdata[7:0];
          cfg_clear        = 1'b1;
        end
        CFG_SAMPLE_RATE: begin
          cfg_nxt.sample_rate = cfg_wdata;
          cfg_clear           = 1'b1;
        end
        CFG_WORDS_PER_FRAME: begin
          cfg_nxt.words_per_frame = cfg_wdata[11:0];
          cfg_clear               = 1'b1;
        end
        default: begin
          cfg_clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dev_type        <= 8'd1;
      cfg_r.sample_rate     <= 32'd1;
      cfg_r.words_per_frame <= 12'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sfp_front #(
    .MAX_FRAME_WORDS (MAX_FRAME_WORDS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .cfg_clear (cfg_clear),
    .q_full    (q_full),
    .push      (push),
    .push_ent  (push_ent)
  );

  sfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ent  (push_ent),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  sfp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .head        (head),
    .q_not_empty (q_not_empty),
    .pop         (pop),
    .out_ch      (out_ch)
  );

  // Never push into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) !(push && q_full))
    else $error("request pushed into full queue");

  // Frame start flag only on the sync byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.frame_first |-> out_ch.data.out_byte == SYNC0_BYTE)
    else $error("frame_first on a byte other than 0x55");

  // Frame end flag only on the line feed
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.frame_last |-> out_ch.data.out_byte == LF_BYTE)
    else $error("frame_last on a byte other than 0x0A");

  // Never pop an empty queue
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_not_empty)
    else $error("pop from empty queue");

endmodule

// File: verif/tb_top.sv
module tb_top
  import sfp_pkg::*;
();

  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS   = 310;
  localparam int unsigned MAX_REPORTS    = 100;
  localparam logic [1:0]  CFG_SPARE      = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_wdata;

  sfp_stream_if #(.item_t(in_item_t))  in_if ();
  sfp_stream_if #(.item_t(out_item_t)) out_if ();

  sample_frame_packer_crc16_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Words waiting to be offered, and bytes the packer still owes us
  in_item_t  pending_words[$];
  out_item_t expected_bytes[$];

  // Shadow of the packer: settings, words sent in the open frame, running CRC
  cfg_t        cfg_shadow;
  logic [11:0] word_cnt;
  logic [15:0] crc_acc;

  int unsigned err_cnt      = 0;
  int unsigned quiet_cycles = 0;
  int unsigned src_gap      = 0;
  int unsigned snk_gap      = 0;
  int unsigned hold_left    = 0;
  logic        src_idle_on  = 1'b1;
  logic        snk_idle_on  = 1'b1;
  logic        hold_req     = 1'b0;
  logic        hold_done    = 1'b0;
  logic        in_taken     = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) pick_gap = 0;
    else if (r < 92) pick_gap = $urandom_range(1, 3);
    else if (r < 98) pick_gap = $urandom_range(4, 12);
    else pick_gap = $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: pick_word = 32'h0000_0000;
      1: pick_word = 32'hFFFF_FFFF;
      2: pick_word = 32'h7F80_0000;
      3: pick_word = 32'hBF80_0000;
      default: pick_word = $urandom();
    endcase
  endfunction

  function automatic logic framing_on();
    framing_on = cfg_shadow.words_per_frame != 0 &&
                 cfg_shadow.words_per_frame <= MAX_WORDS &&
                 cfg_shadow.sample_rate != 0;
  endfunction

  // CRC-16/CCITT-FALSE, one input bit at a time, MSB first
  function automatic logic [15:0] crc_shift(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0};
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic emit_byte(input logic [7:0] b, input logic first, input logic last,
                           input logic in_crc);
    out_item_t e;
    e.out_byte    = b;
    e.frame_first = first;
    e.frame_last  = last;
    expected_bytes.push_back(e);
    if (in_crc) crc_acc = crc_shift(crc_acc, b);
  endtask

  // Predict the bytes one accepted word produces
  task automatic pack_word(input in_item_t w);
    logic [15:0] flen;
    logic [15:0] crc_snap;
    if (framing_on()) begin
      // Open a frame: header bytes
      if (word_cnt == 0) begin
        crc_acc = CRC_INIT;
        flen = 16'(cfg_shadow.words_per_frame) * 16'd4 + FRAME_OVERHEAD;
        emit_byte(SYNC0_BYTE, 1'b1, 1'b0, 1'b1);
        emit_byte(SYNC1_BYTE, 1'b0, 1'b0, 1'b1);
        emit_byte(flen[7:0], 1'b0, 1'b0, 1'b1);
        emit_byte(flen[15:8], 1'b0, 1'b0, 1'b1);
        emit_byte(cfg_shadow.dev_type, 1'b0, 1'b0, 1'b1);
        for (int k = 0; k < 4; k++) emit_byte(cfg_shadow.sample_rate[8*k +: 8], 1'b0, 1'b0, 1'b1);
        for (int k = 0; k < 4; k++) emit_byte(w.timestamp[8*k +: 8], 1'b0, 1'b0, 1'b1);
        emit_byte(cfg_shadow.words_per_frame[7:0], 1'b0, 1'b0, 1'b1);
        emit_byte({4'h0, cfg_shadow.words_per_frame[11:8]}, 1'b0, 1'b0, 1'b1);
      end
      // Payload, least significant byte first
      for (int k = 0; k < 4; k++) emit_byte(w.data_word[8*k +: 8], 1'b0, 1'b0, 1'b1);
      word_cnt = word_cnt + 12'd1;
      // Close the frame: CRC and line ending
      if (word_cnt >= cfg_shadow.words_per_frame) begin
        crc_snap = crc_acc;
        emit_byte(crc_snap[7:0], 1'b0, 1'b0, 1'b0);
        emit_byte(crc_snap[15:8], 1'b0, 1'b0, 1'b0);
        emit_byte(CR_BYTE, 1'b0, 1'b0, 1'b0);
        emit_byte(LF_BYTE, 1'b0, 1'b1, 1'b0);
        word_cnt = '0;
        crc_acc  = CRC_INIT;
      end
    end
  endtask

  task automatic check_byte(input out_item_t got);
    out_item_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("byte %02h with nothing pending", got.out_byte));
    end else begin
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
      if (got.frame_first !== want.frame_first)
        report_mismatch($sformatf("frame_first %b, want %b (byte %02h)",
                                  got.frame_first, want.frame_first, want.out_byte));
      if (got.frame_last !== want.frame_last)
        report_mismatch($sformatf("frame_last %b, want %b (byte %02h)",
                                  got.frame_last, want.frame_last, want.out_byte));
    end
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_if.valid && in_if.ready;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) pack_word(in_if.data);
      if (out_if.valid && out_if.ready) check_byte(out_if.data);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Request driver: advance on acceptance, insert gaps between requests
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (src_gap != 0) begin
        src_gap <= src_gap - 1;
        in_if.valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_if.data  <= pending_words.pop_front();
        in_if.valid <= 1'b1;
        src_gap     <= src_idle_on ? pick_gap() : 0;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done    <= 1'b1;
      hold_left    <= LONG_HOLD;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (snk_gap != 0) begin
      snk_gap      <= snk_gap - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (snk_idle_on && $urandom_range(0, 3) == 0) snk_gap <= pick_gap();
    end
  end

  task automatic queue_word(input logic [31:0] d, input logic [31:0] ts);
    in_item_t w;
    w.data_word = d;
    w.timestamp = ts;
    pending_words.push_back(w);
  endtask

  // Hold the sender until every byte is back, then let the packer settle
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_if.valid || expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      CFG_DEV_TYPE:        cfg_shadow.dev_type        = val[7:0];
      CFG_SAMPLE_RATE:     cfg_shadow.sample_rate     = val;
      CFG_WORDS_PER_FRAME: cfg_shadow.words_per_frame = val[11:0];
      default: ;
    endcase
    // A write to a real register drops the open frame
    if (idx != CFG_SPARE) begin
      word_cnt = '0;
      crc_acc  = CRC_INIT;
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    int unsigned r;
    int unsigned n;
    int unsigned n_items;
    int unsigned enabled_items;
    int unsigned phase_no;
    logic [2:0]  wr_mask;
    logic [31:0] wd;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_shadow.dev_type        = 8'd1;
    cfg_shadow.sample_rate     = 32'd1;
    cfg_shadow.words_per_frame = 12'd1;
    word_cnt = '0;
    crc_acc  = CRC_INIT;
    enabled_items = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: one-word frames, field extremes
    queue_word(32'h0000_0000, 32'h0000_0000);
    queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_word(32'h3F80_0000, 32'h1234_5678);
    wait_idle();

    // Top register values; one full frame of 3, then an open frame
    write_reg(CFG_DEV_TYPE, 32'hFFFF_FFFF);
    write_reg(CFG_SAMPLE_RATE, 32'hFFFF_FFFF);
    write_reg(CFG_WORDS_PER_FRAME, 32'hFFFF_F003);
    repeat (4) queue_word($urandom(), $urandom());
    wait_idle();

    // Unknown index must leave the open frame alone
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    repeat (2) queue_word($urandom(), $urandom());
    wait_idle();

    // Largest frame: start it, then abandon it with a write
    write_reg(CFG_WORDS_PER_FRAME, 32'h0000_0800);
    repeat (2) queue_word($urandom(), $urandom());
    wait_idle();
    write_reg(CFG_DEV_TYPE, 32'h0000_0000);

    // Framing disabled: count above the limit, count zero, rate zero
    write_reg(CFG_WORDS_PER_FRAME, 32'h0000_0FFF);
    repeat (2) queue_word($urandom(), $urandom());
    wait_idle();
    write_reg(CFG_WORDS_PER_FRAME, 32'h0000_0801);
    queue_word($urandom(), $urandom());
    wait_idle();
    write_reg(CFG_WORDS_PER_FRAME, 32'h0000_0000);
    queue_word($urandom(), $urandom());
    wait_idle();
    write_reg(CFG_WORDS_PER_FRAME, 32'h0000_0002);
    write_reg(CFG_SAMPLE_RATE, 32'h0000_0000);
    repeat (2) queue_word($urandom(), $urandom());
    wait_idle();

    // Back on, one frame plus an open one
    write_reg(CFG_SAMPLE_RATE, 32'h0001_F400);
    repeat (3) queue_word(pick_word(), $urandom());

    // Random phases: new settings while idle, then a burst of words
    phase_no = 0;
    while (enabled_items < RANDOM_ITEMS) begin
      wait_idle();
      src_idle_on = ($urandom_range(0, 4) != 0);
      snk_idle_on = ($urandom_range(0, 4) != 0);
      if (phase_no == 2) begin
        // Fill the packer while the sink holds off
        write_reg(CFG_SAMPLE_RATE, $urandom() | 32'h1);
        write_reg(CFG_WORDS_PER_FRAME, 32'd4);
        src_idle_on = 1'b0;
        hold_req    = 1'b1;
        n_items     = 24;
      end else begin
        if ($urandom_range(0, 5) == 0) begin
          write_reg(CFG_SPARE, $urandom());
        end else begin
          do wr_mask = 3'($urandom_range(1, 7));
          while (wr_mask == 0);
          if (wr_mask[0]) begin
            r = $urandom_range(0, 99);
            wd = $urandom();
            if (r < 10) wd[7:0] = 8'h00;
            else if (r < 20) wd[7:0] = 8'hFF;
            write_reg(CFG_DEV_TYPE, wd);
          end
          if (wr_mask[1]) begin
            r = $urandom_range(0, 99);
            if (r < 8) wd = 32'h0000_0000;
            else if (r < 16) wd = 32'hFFFF_FFFF;
            else if (r < 24) wd = 32'h0000_0001;
            else wd = $urandom();
            write_reg(CFG_SAMPLE_RATE, wd);
          end
          if (wr_mask[2]) begin
            r = $urandom_range(0, 99);
            wd = $urandom();
            if (r < 5) wd[11:0] = 12'd0;
            else if (r < 10) wd[11:0] = 12'($urandom_range(MAX_WORDS + 1, 4095));
            else if (r < 13) wd[11:0] = 12'(MAX_WORDS);
            else if (r < 80) wd[11:0] = 12'($urandom_range(1, 6));
            else wd[11:0] = 12'($urandom_range(7, 24));
            write_reg(CFG_WORDS_PER_FRAME, wd);
          end
        end
        n = 32'(cfg_shadow.words_per_frame);
        if (!framing_on() || n == MAX_WORDS) n_items = $urandom_range(1, 3);
        else n_items = n * $urandom_range(1, 2) + $urandom_range(0, n - 1);
      end
      if (framing_on()) enabled_items += n_items;
      repeat (n_items) queue_word(pick_word(), $urandom());
      phase_no++;
    end

    wait_idle();
    if (err_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
